### sv/ncr_pkg.sv
// Shared types and constants for the Niggli cell reduction unit.
`default_nettype none
package ncr_pkg;

  localparam int COORD_WIDTH_DEF = 32;
  localparam int CFG_IDX_W = 8;
  localparam logic [31:0] TOL_RESET = 32'd42950;
  localparam logic [15:0] MAXP_RESET = 16'd1000;

  localparam logic [CFG_IDX_W-1:0] REG_TOLERANCE = 8'd0;
  localparam logic [CFG_IDX_W-1:0] REG_MAX_PASSES = 8'd1;

  localparam logic [1:0] ST_REDUCED = 2'd0;
  localparam logic [1:0] ST_LIMIT = 2'd1;
  localparam logic [1:0] ST_OVF = 2'd2;

  // Krivy-Gruber step, numbered from zero
  typedef enum logic [2:0] {
    STP_1 = 3'd0, STP_2 = 3'd1, STP_3 = 3'd2, STP_4 = 3'd3,
    STP_5 = 3'd4, STP_6 = 3'd5, STP_7 = 3'd6, STP_8 = 3'd7
  } step_t;

  // metric term order: A, B, C, xi, eta, zeta
  localparam int NTERM = 6;
  localparam logic [1:0] TERM_U [NTERM] = '{2'd0, 2'd1, 2'd2, 2'd1, 2'd0, 2'd0};
  localparam logic [1:0] TERM_V [NTERM] = '{2'd0, 2'd1, 2'd2, 2'd2, 2'd2, 2'd1};

  // fixed step matrices, entry [i*3+j]: new vector j += t * old vector i
  localparam logic signed [1:0] MAT_STEP1 [9] = '{2'sd0, -2'sd1, 2'sd0, -2'sd1, 2'sd0,
                                                  2'sd0, 2'sd0, 2'sd0, -2'sd1};
  localparam logic signed [1:0] MAT_STEP2 [9] = '{-2'sd1, 2'sd0, 2'sd0, 2'sd0, 2'sd0,
                                                  -2'sd1, 2'sd0, -2'sd1, 2'sd0};
  localparam logic signed [1:0] MAT_STEP8 [9] = '{2'sd1, 2'sd0, 2'sd1, 2'sd0, 2'sd1,
                                                  2'sd1, 2'sd0, 2'sd0, 2'sd1};

  typedef struct packed {
    logic       load;
    logic       mac_issue;
    logic [2:0] mac_term;
    logic [1:0] mac_comp;
    logic       apply;
    step_t      step;
    logic       conv;
  } ncr_cmd_t;

  typedef struct packed {
    logic fire;
    logic ovf;
  } ncr_sts_t;

endpackage
`default_nettype wire

### sv/niggli_cell_reduction_unit.sv
// Top level of the Niggli cell reduction unit: config registers and wiring.
`default_nettype none
// Reduces one lattice basis (three Q16.16 column vectors) to Niggli form with
// the Krivy-Gruber steps 1 to 8, one basis at a time. After a basis beat is
// taken, the metric is built by a single shared multiplier, one product per
// cycle, and then drained; each step is tested in turn, and a firing step
// updates the basis in its test cycle and then waits for a metric rebuild.
// The input is blocked until the result beat is taken. tolerance and
// max_passes are to be written through the cfg channel only while the unit
// is idle; the unit itself does not enforce this. status is 0 reduced,
// 1 pass limit, 2 overflow.
module niggli_cell_reduction_unit #(
  parameter int COORD_WIDTH = ncr_pkg::COORD_WIDTH_DEF
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          in_valid,
  output logic                               in_ready,
  input  wire logic signed [31:0]            in_a_x,
  input  wire logic signed [31:0]            in_a_y,
  input  wire logic signed [31:0]            in_a_z,
  input  wire logic signed [31:0]            in_b_x,
  input  wire logic signed [31:0]            in_b_y,
  input  wire logic signed [31:0]            in_b_z,
  input  wire logic signed [31:0]            in_c_x,
  input  wire logic signed [31:0]            in_c_y,
  input  wire logic signed [31:0]            in_c_z,
  output logic                               out_valid,
  input  wire logic                          out_ready,
  output logic signed [31:0]                 out_red_a_x,
  output logic signed [31:0]                 out_red_a_y,
  output logic signed [31:0]                 out_red_a_z,
  output logic signed [31:0]                 out_red_b_x,
  output logic signed [31:0]                 out_red_b_y,
  output logic signed [31:0]                 out_red_b_z,
  output logic signed [31:0]                 out_red_c_x,
  output logic signed [31:0]                 out_red_c_y,
  output logic signed [31:0]                 out_red_c_z,
  output logic [1:0]                         out_status,
  input  wire logic                          cfg_valid,
  output logic                               cfg_ready,
  input  wire logic [ncr_pkg::CFG_IDX_W-1:0] cfg_index,
  input  wire logic [31:0]                   cfg_data
);
  logic [31:0] tol_r;
  logic [15:0] maxp_r;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tol_r <= ncr_pkg::TOL_RESET;
      maxp_r <= ncr_pkg::MAXP_RESET;
    end else if (cfg_valid) begin
      if (cfg_index == ncr_pkg::REG_TOLERANCE) tol_r <= cfg_data;
      else if (cfg_index == ncr_pkg::REG_MAX_PASSES) maxp_r <= cfg_data[15:0];
    end
  end

  ncr_pkg::ncr_cmd_t cmd;
  ncr_pkg::ncr_sts_t sts;
  logic signed [31:0] in_comp [9];
  logic signed [31:0] out_comp [9];

  assign in_comp[0] = in_a_x;
  assign in_comp[1] = in_a_y;
  assign in_comp[2] = in_a_z;
  assign in_comp[3] = in_b_x;
  assign in_comp[4] = in_b_y;
  assign in_comp[5] = in_b_z;
  assign in_comp[6] = in_c_x;
  assign in_comp[7] = in_c_y;
  assign in_comp[8] = in_c_z;
  assign out_red_a_x = out_comp[0];
  assign out_red_a_y = out_comp[1];
  assign out_red_a_z = out_comp[2];
  assign out_red_b_x = out_comp[3];
  assign out_red_b_y = out_comp[4];
  assign out_red_b_z = out_comp[5];
  assign out_red_c_x = out_comp[6];
  assign out_red_c_y = out_comp[7];
  assign out_red_c_z = out_comp[8];

  ncr_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .max_passes (maxp_r),
    .cmd        (cmd),
    .sts        (sts)
  );

  ncr_datapath #(
    .COORD_WIDTH (COORD_WIDTH)
  ) u_dp (
    .clk      (clk),
    .rst_n    (rst_n),
    .cmd      (cmd),
    .sts      (sts),
    .tol      (tol_r),
    .in_comp  (in_comp),
    .out_comp (out_comp),
    .status   (out_status)
  );

endmodule
`default_nettype wire

### sv/ncr_datapath.sv
// Datapath: basis registers, metric MAC, step tests and basis update.
`default_nettype none
module ncr_datapath #(
  parameter int COORD_WIDTH = ncr_pkg::COORD_WIDTH_DEF
) (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire ncr_pkg::ncr_cmd_t   cmd,
  output ncr_pkg::ncr_sts_t        sts,
  input  wire logic [31:0]         tol,
  input  wire logic signed [31:0]  in_comp [9],
  output logic signed [31:0]       out_comp [9],
  output logic [1:0]               status
);
  localparam int CW = COORD_WIDTH;
  localparam int MW = 2 * CW + 6;
  localparam int XW = ((CW > 32) ? CW : 32) + 1;
  localparam int SW = XW + 2;
  localparam logic signed [SW-1:0] CW_MAX = {{(SW-CW+1){1'b0}}, {(CW-1){1'b1}}};
  localparam logic signed [SW-1:0] CW_MIN = ~CW_MAX;
  localparam logic signed [XW-1:0] O_MAX = {{(XW-31){1'b0}}, {31{1'b1}}};
  localparam logic signed [XW-1:0] O_MIN = ~O_MAX;

  logic signed [CW-1:0] bas_r [3][3];
  logic signed [MW-1:0] m_r [ncr_pkg::NTERM];
  logic signed [MW-1:0] acc_r;
  logic signed [2*CW-1:0] prod_r;
  logic [2:0] pterm_r;
  logic [1:0] pcomp_r;
  logic pvalid_r;
  logic ovf_r;

  function automatic logic [CW:0] sat_cw(input logic signed [SW-1:0] v);
    logic [CW:0] r;
    if (v > CW_MAX) r = {1'b1, CW_MAX[CW-1:0]};
    else if (v < CW_MIN) r = {1'b1, CW_MIN[CW-1:0]};
    else r = {1'b0, v[CW-1:0]};
    return r;
  endfunction

  // ---- metric MAC, one product per beat of the sequencer
  logic signed [CW-1:0] mu, mv;
  logic [1:0] vu, vv;
  always_comb begin
    vu = ncr_pkg::TERM_U[cmd.mac_term];
    vv = ncr_pkg::TERM_V[cmd.mac_term];
    mu = '0;
    mv = '0;
    for (int i = 0; i < 3; i++) begin
      for (int k = 0; k < 3; k++) begin
        if (vu == 2'(i) && cmd.mac_comp == 2'(k)) mu = bas_r[i][k];
        if (vv == 2'(i) && cmd.mac_comp == 2'(k)) mv = bas_r[i][k];
      end
    end
  end

  logic signed [MW-1:0] acc_sum;
  assign acc_sum = ((pcomp_r == 2'd0) ? MW'(0) : acc_r) + MW'(prod_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pvalid_r <= 1'b0;
    end else begin
      pvalid_r <= cmd.mac_issue;
    end
    prod_r <= mu * mv;
    pterm_r <= cmd.mac_term;
    pcomp_r <= cmd.mac_comp;
    if (pvalid_r) begin
      acc_r <= acc_sum;
      if (pcomp_r == 2'd2) begin
        m_r[pterm_r] <= (pterm_r >= 3'd3) ? (acc_sum <<< 1) : acc_sum;
      end
    end
  end

  // ---- step tests
  logic signed [MW-1:0] eps, neps, mA, mB, mC, xi, eta, zeta;
  assign eps = MW'({1'b0, tol});
  assign neps = -eps;
  assign mA = m_r[0];
  assign mB = m_r[1];
  assign mC = m_r[2];
  assign xi = m_r[3];
  assign eta = m_r[4];
  assign zeta = m_r[5];

  function automatic logic signed [MW-1:0] absm(input logic signed [MW-1:0] x);
    return x[MW-1] ? -x : x;
  endfunction

  function automatic logic nearm(input logic signed [MW-1:0] x,
                                 input logic signed [MW-1:0] e);
    return !(absm(x) > e);
  endfunction

  function automatic logic shear_fire(input logic signed [MW-1:0] t, d, f, s, e);
    return (absm(t) > d + e) ||
           (nearm(d - t, e) && ((f + f) < (s - e))) ||
           (nearm(d + t, e) && (s < -e));
  endfunction

  function automatic logic signed [1:0] atype(input logic signed [MW-1:0] t,
                                              input logic signed [MW-1:0] e);
    if (t < -e) return -2'sd1;
    if (t > e) return 2'sd1;
    return 2'sd0;
  endfunction

  logic signed [1:0] ty [3];
  logic signed [1:0] sg [3];
  logic [1:0] nneg, npos;
  logic nz, all_neg, f3, f4;
  logic signed [MW-1:0] sum8;
  logic signed [1:0] mat [9];
  logic fire;

  function automatic logic signed [1:0] shear_coef(input logic signed [MW-1:0] t);
    if (t > 0) return -2'sd1;
    if (t < 0) return 2'sd1;
    return 2'sd0;
  endfunction

  always_comb begin
    ty[0] = atype(xi, eps);
    ty[1] = atype(eta, eps);
    ty[2] = atype(zeta, eps);
    nneg = 2'(ty[0] == -2'sd1) + 2'(ty[1] == -2'sd1) + 2'(ty[2] == -2'sd1);
    npos = 2'(ty[0] == 2'sd1) + 2'(ty[1] == 2'sd1) + 2'(ty[2] == 2'sd1);
    nz = (ty[0] != 0) && (ty[1] != 0) && (ty[2] != 0);
    all_neg = (nneg == 2'd3);
    f3 = nz && !nneg[0];
    f4 = !all_neg && (!nz || nneg[0]);
    for (int q = 0; q < 3; q++) sg[q] = (ty[q] == 2'sd1) ? -2'sd1 : 2'sd1;
    if (npos[0] && !nz) begin
      // odd sign count: flip the last neutral angle
      priority if (ty[2] == 0) sg[2] = -2'sd1;
      else if (ty[1] == 0) sg[1] = -2'sd1;
      else if (ty[0] == 0) sg[0] = -2'sd1;
    end
    sum8 = xi + eta + zeta + mA + mB;

    for (int q = 0; q < 9; q++) mat[q] = 2'sd0;
    mat[0] = 2'sd1;
    mat[4] = 2'sd1;
    mat[8] = 2'sd1;
    fire = 1'b0;
    unique case (cmd.step)
      ncr_pkg::STP_1: begin
        fire = (mA > mB + eps) || (nearm(mA - mB, eps) && (absm(xi) > absm(eta) + eps));
        mat = ncr_pkg::MAT_STEP1;
      end
      ncr_pkg::STP_2: begin
        fire = (mB > mC + eps) || (nearm(mB - mC, eps) && (absm(eta) > absm(zeta) + eps));
        mat = ncr_pkg::MAT_STEP2;
      end
      ncr_pkg::STP_3: begin
        fire = f3;
        mat[0] = (ty[0] == -2'sd1) ? -2'sd1 : 2'sd1;
        mat[4] = (ty[1] == -2'sd1) ? -2'sd1 : 2'sd1;
        mat[8] = (ty[2] == -2'sd1) ? -2'sd1 : 2'sd1;
      end
      ncr_pkg::STP_4: begin
        fire = f4;
        mat[0] = sg[0];
        mat[4] = sg[1];
        mat[8] = sg[2];
      end
      ncr_pkg::STP_5: begin
        fire = shear_fire(xi, mB, eta, zeta, eps);
        mat[5] = shear_coef(xi);
      end
      ncr_pkg::STP_6: begin
        fire = shear_fire(eta, mA, xi, zeta, eps);
        mat[2] = shear_coef(eta);
      end
      ncr_pkg::STP_7: begin
        fire = shear_fire(zeta, mA, xi, eta, eps);
        mat[1] = shear_coef(zeta);
      end
      ncr_pkg::STP_8: begin
        fire = (sum8 < neps) ||
               (nearm(sum8, eps) && ((mA + eta) + (mA + eta) + zeta > eps));
        mat = ncr_pkg::MAT_STEP8;
      end
      default: fire = 1'b0;
    endcase
  end

  // ---- basis update and load
  logic signed [SW-1:0] nsum [3][3];
  logic [CW:0] nsat [3][3];
  logic [CW:0] lsat [3][3];
  logic new_ovf, in_ovf;
  always_comb begin
    new_ovf = 1'b0;
    in_ovf = 1'b0;
    for (int j = 0; j < 3; j++) begin
      for (int k = 0; k < 3; k++) begin
        nsum[j][k] = '0;
        for (int i = 0; i < 3; i++) begin
          if (mat[i*3+j] == 2'sd1) nsum[j][k] = nsum[j][k] + SW'(bas_r[i][k]);
          else if (mat[i*3+j] == -2'sd1) nsum[j][k] = nsum[j][k] - SW'(bas_r[i][k]);
        end
        nsat[j][k] = sat_cw(nsum[j][k]);
        new_ovf = new_ovf | nsat[j][k][CW];
        lsat[j][k] = sat_cw(SW'(in_comp[j*3+k]));
        in_ovf = in_ovf | lsat[j][k][CW];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ovf_r <= 1'b0;
    end else if (cmd.load) begin
      ovf_r <= in_ovf;
    end else if (cmd.apply) begin
      ovf_r <= ovf_r | new_ovf;
    end
    for (int j = 0; j < 3; j++) begin
      for (int k = 0; k < 3; k++) begin
        if (cmd.load) bas_r[j][k] <= lsat[j][k][CW-1:0];
        else if (cmd.apply) bas_r[j][k] <= nsat[j][k][CW-1:0];
      end
    end
  end

  // ---- result
  logic signed [XW-1:0] ox;
  logic oclamp;
  always_comb begin
    oclamp = 1'b0;
    for (int q = 0; q < 9; q++) begin
      ox = XW'(bas_r[q/3][q%3]);
      if (ox > O_MAX) begin
        out_comp[q] = O_MAX[31:0];
        oclamp = 1'b1;
      end else if (ox < O_MIN) begin
        out_comp[q] = O_MIN[31:0];
        oclamp = 1'b1;
      end else begin
        out_comp[q] = ox[31:0];
      end
    end
  end

  assign status = (ovf_r || oclamp) ? ncr_pkg::ST_OVF :
                  (cmd.conv ? ncr_pkg::ST_REDUCED : ncr_pkg::ST_LIMIT);
  assign sts.fire = fire;
  assign sts.ovf = ovf_r;

endmodule
`default_nettype wire

### sv/ncr_ctrl.sv
// Controller: pass and step sequencing, metric MAC sequencing, handshakes.
`default_nettype none
module ncr_ctrl (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               in_valid,
  output logic                    in_ready,
  output logic                    out_valid,
  input  wire logic               out_ready,
  input  wire logic [15:0]        max_passes,
  output ncr_pkg::ncr_cmd_t       cmd,
  input  wire ncr_pkg::ncr_sts_t  sts
);
  typedef enum logic [4:0] {
    S_IDLE = 5'b00001,
    S_CHK  = 5'b00010,
    S_MET  = 5'b00100,
    S_EVAL = 5'b01000,
    S_OUT  = 5'b10000
  } state_t;

  state_t state_r, state_nxt;
  ncr_pkg::step_t step_r, step_nxt;
  logic [15:0] pass_r, pass_nxt;
  logic [2:0] term_r, term_nxt;
  logic [1:0] comp_r, comp_nxt;
  logic drain_r, drain_nxt;
  logic init_r, init_nxt;
  logic conv_r, conv_nxt;

  logic restart_step, last_issue;
  assign restart_step = (step_r == ncr_pkg::STP_2) || (step_r == ncr_pkg::STP_5) ||
                        (step_r == ncr_pkg::STP_6) || (step_r == ncr_pkg::STP_7) ||
                        (step_r == ncr_pkg::STP_8);
  assign last_issue = (term_r == 3'(ncr_pkg::NTERM - 1)) && (comp_r == 2'd2);

  always_comb begin
    state_nxt = state_r;
    step_nxt = step_r;
    pass_nxt = pass_r;
    term_nxt = term_r;
    comp_nxt = comp_r;
    drain_nxt = drain_r;
    init_nxt = init_r;
    conv_nxt = conv_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          state_nxt = S_CHK;
          conv_nxt = 1'b0;
          pass_nxt = '0;
          step_nxt = ncr_pkg::STP_1;
        end
      end
      S_CHK: begin
        if (sts.ovf || max_passes == 16'd0) begin
          state_nxt = S_OUT;
        end else begin
          state_nxt = S_MET;
          init_nxt = 1'b1;
          term_nxt = '0;
          comp_nxt = '0;
          drain_nxt = 1'b0;
        end
      end
      S_MET: begin
        if (!drain_r) begin
          if (last_issue) begin
            drain_nxt = 1'b1;
          end else if (comp_r == 2'd2) begin
            comp_nxt = '0;
            term_nxt = term_r + 3'd1;
          end else begin
            comp_nxt = comp_r + 2'd1;
          end
        end else begin
          init_nxt = 1'b0;
          if (init_r) begin
            state_nxt = S_EVAL;
          end else if (sts.ovf) begin
            state_nxt = S_OUT;
          end else if (restart_step) begin
            // pass ended by a restart
            pass_nxt = pass_r + 16'd1;
            step_nxt = ncr_pkg::STP_1;
            state_nxt = ({1'b0, pass_r} + 17'd1 >= {1'b0, max_passes}) ? S_OUT : S_EVAL;
          end else begin
            step_nxt = ncr_pkg::step_t'(step_r + 3'd1);
            state_nxt = S_EVAL;
          end
        end
      end
      S_EVAL: begin
        if (sts.fire) begin
          state_nxt = S_MET;
          term_nxt = '0;
          comp_nxt = '0;
          drain_nxt = 1'b0;
        end else if (step_r == ncr_pkg::STP_8) begin
          conv_nxt = 1'b1;
          state_nxt = S_OUT;
        end else begin
          step_nxt = ncr_pkg::step_t'(step_r + 3'd1);
        end
      end
      S_OUT: begin
        if (out_ready) state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      step_r <= ncr_pkg::STP_1;
      pass_r <= '0;
      term_r <= '0;
      comp_r <= '0;
      drain_r <= 1'b0;
      init_r <= 1'b0;
      conv_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      step_r <= step_nxt;
      pass_r <= pass_nxt;
      term_r <= term_nxt;
      comp_r <= comp_nxt;
      drain_r <= drain_nxt;
      init_r <= init_nxt;
      conv_r <= conv_nxt;
    end
  end

  assign in_ready = (state_r == S_IDLE);
  assign out_valid = (state_r == S_OUT);
  assign cmd.load = (state_r == S_IDLE) && in_valid;
  assign cmd.mac_issue = (state_r == S_MET) && !drain_r;
  assign cmd.mac_term = term_r;
  assign cmd.mac_comp = comp_r;
  assign cmd.apply = (state_r == S_EVAL) && sts.fire;
  assign cmd.step = step_r;
  assign cmd.conv = conv_r;

endmodule
`default_nettype wire
